// ===== rtl/sitf_pkg.sv =====
// ----------------------------------------------------------------------------
// sitf_pkg
// Shared types, widths and constants of the serial idle-timeout framer.
// ----------------------------------------------------------------------------
package sitf_pkg;

    // Receive store geometry.
    localparam int RX_DEPTH   = 256;
    localparam int ADDR_W     = $clog2(RX_DEPTH);
    localparam int IDX_W      = $clog2(RX_DEPTH + 1);
    localparam int RXCAP_W    = 9;
    localparam int CMP_W      = (IDX_W > RXCAP_W) ? IDX_W : RXCAP_W;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int MS_W       = 16;
    localparam int LEN_W      = 16;
    localparam int TIMEOUT_W  = 12;
    localparam int TXCAP_W    = 16;
    localparam int TIMER_W    = 17;
    localparam int FUNC_W     = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 48;

    // Timing constants in milliseconds.
    localparam int FRAME_HOLD_MS    = 1000;
    localparam int TIMEOUT_MIN      = 10;
    localparam int TIMEOUT_MAX      = 3000;
    localparam int TIMEOUT_FALLBACK = 100;
    localparam int TIMEOUT_RESET    = 50;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_RX_CAP  = 2'd1,
        CFG_TX_CAP  = 2'd2
    } t_cfg_idx;

    // Operation codes of an input item.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE = 3'd0,
        FUNC_TICK    = 3'd1,
        FUNC_READ    = 3'd2,
        FUNC_TAKE    = 3'd3,
        FUNC_WRITE   = 3'd4
    } t_func;

    // Transmit bus state.
    typedef enum logic [1:0] {
        BUS_FREE = 2'd0,
        BUS_WAIT = 2'd1,
        BUS_XFER = 2'd2
    } t_bus;

    // Write command to the receive store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

    // Result of one item, without the byte that comes from the store.
    typedef struct packed {
        logic             rd_en;
        logic [LEN_W-1:0] length;
        logic             start_tx;
        logic [LEN_W-1:0] tx_length;
        t_bus             bus_status;
        logic             frame_ready;
        logic             overflow;
    } t_result;

endpackage

// ===== rtl/sitf_store.sv =====
// ----------------------------------------------------------------------------
// sitf_store
// Receive byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sitf_store (
    input  logic                          i_clk,
    input  sitf_pkg::t_store_wr           i_wr,
    input  logic                          i_rd_en,
    input  logic [sitf_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [sitf_pkg::BYTE_W-1:0]   o_rd_data
);
    import sitf_pkg::*;

    logic [BYTE_W-1:0] r_mem [RX_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Byte write.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sitf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitf_ctrl
// Framing and transmit control: holds the counters, timers and bus state,
// applies configuration writes and works out the result of each item.
// ----------------------------------------------------------------------------
module sitf_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sitf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sitf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_accept,
    input  logic [sitf_pkg::FUNC_W-1:0]       i_func,
    input  logic [sitf_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic [sitf_pkg::MS_W-1:0]         i_elapsed_ms,
    input  logic                              i_uart_busy,
    input  logic [sitf_pkg::BYTE_W-1:0]       i_read_index,
    input  logic [sitf_pkg::LEN_W-1:0]        i_read_max,
    input  logic [sitf_pkg::LEN_W-1:0]        i_write_count,
    output sitf_pkg::t_store_wr               o_wr,
    output logic [sitf_pkg::ADDR_W-1:0]       o_rd_addr,
    output sitf_pkg::t_result                 o_res
);
    import sitf_pkg::*;

    logic [TIMEOUT_W-1:0] r_timeout, n_timeout;
    logic [RXCAP_W-1:0]   r_rx_cap, n_rx_cap;
    logic [TXCAP_W-1:0]   r_tx_cap, n_tx_cap;
    logic [IDX_W-1:0]     r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]     r_frame_len, n_frame_len;
    logic [TIMER_W-1:0]   r_rx_timer, n_rx_timer;
    logic [TIMER_W-1:0]   r_tx_timer, n_tx_timer;
    t_bus                 r_bus, n_bus;
    logic [LEN_W-1:0]     r_tx_pend, n_tx_pend;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_W'(TIMEOUT_RESET);
            r_rx_cap    <= '0;
            r_tx_cap    <= '0;
            r_wr_idx    <= '0;
            r_frame_len <= '0;
            r_rx_timer  <= '0;
            r_tx_timer  <= '0;
            r_bus       <= BUS_FREE;
            r_tx_pend   <= '0;
        end else begin
            r_timeout   <= n_timeout;
            r_rx_cap    <= n_rx_cap;
            r_tx_cap    <= n_tx_cap;
            r_wr_idx    <= n_wr_idx;
            r_frame_len <= n_frame_len;
            r_rx_timer  <= n_rx_timer;
            r_tx_timer  <= n_tx_timer;
            r_bus       <= n_bus;
            r_tx_pend   <= n_tx_pend;
        end
    end

    // Derived values shared by the item logic.
    logic [CMP_W-1:0]     cap;
    logic [TIMER_W-1:0]   timeout_x;
    logic [TIMER_W-1:0]   hold;
    logic [TIMER_W-1:0]   rx_sum;
    logic [TIMER_W-1:0]   tx_sum;
    logic [TIMEOUT_W-1:0] cfg_timeout;

    assign cap = (CMP_W'(r_rx_cap) < CMP_W'(RX_DEPTH)) ? CMP_W'(r_rx_cap)
                                                        : CMP_W'(RX_DEPTH);
    assign timeout_x   = TIMER_W'(r_timeout);
    assign hold        = timeout_x + TIMER_W'(FRAME_HOLD_MS);
    assign rx_sum      = r_rx_timer + TIMER_W'(i_elapsed_ms);
    assign tx_sum      = r_tx_timer + TIMER_W'(i_elapsed_ms);
    assign cfg_timeout = i_cfg_data[TIMEOUT_W-1:0];
    assign o_rd_addr   = ADDR_W'(i_read_index);

    // Next state and result.
    always_comb begin
        t_bus             bus_x;
        logic [LEN_W-1:0] pend_x;
        logic [LEN_W-1:0] cnt;

        n_timeout   = r_timeout;
        n_rx_cap    = r_rx_cap;
        n_tx_cap    = r_tx_cap;
        n_wr_idx    = r_wr_idx;
        n_frame_len = r_frame_len;
        n_rx_timer  = r_rx_timer;
        n_tx_timer  = r_tx_timer;
        n_bus       = r_bus;
        n_tx_pend   = r_tx_pend;
        bus_x       = r_bus;
        pend_x      = r_tx_pend;
        cnt         = i_write_count;

        o_wr.en   = 1'b0;
        o_wr.addr = r_wr_idx[ADDR_W-1:0];
        o_wr.data = i_rx_byte;

        o_res.rd_en     = 1'b0;
        o_res.length    = '0;
        o_res.start_tx  = 1'b0;
        o_res.tx_length = '0;
        o_res.overflow  = 1'b0;

        if (i_cfg_we) begin
            // Configuration writes; the user must keep the block idle when they come; it does not enforce that.
            unique case (i_cfg_idx)
                CFG_TIMEOUT: begin
                    if (cfg_timeout < TIMEOUT_W'(TIMEOUT_MIN) ||
                        cfg_timeout > TIMEOUT_W'(TIMEOUT_MAX)) begin
                        n_timeout = TIMEOUT_W'(TIMEOUT_FALLBACK);
                    end else begin
                        n_timeout = cfg_timeout;
                    end
                end
                CFG_RX_CAP: begin
                    n_rx_cap    = i_cfg_data[RXCAP_W-1:0];
                    n_wr_idx    = '0;
                    n_frame_len = '0;
                    n_rx_timer  = '0;
                end
                CFG_TX_CAP: begin
                    n_tx_cap   = i_cfg_data[TXCAP_W-1:0];
                    n_bus      = BUS_FREE;
                    n_tx_pend  = '0;
                    n_tx_timer = '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            unique case (i_func)
                FUNC_RX_BYTE: begin
                    // Store the byte, or flag it dropped when the store is full; with a zero capacity it is ignored.
                    if (cap != '0) begin
                        if (CMP_W'(r_wr_idx) >= cap) begin
                            o_res.overflow = 1'b1;
                        end else begin
                            o_wr.en    = 1'b1;
                            n_wr_idx   = r_wr_idx + IDX_W'(1);
                            n_rx_timer = '0;
                        end
                    end
                end
                FUNC_TICK: begin
                    // Receive side: idle gap, frame latch, then frame hold.
                    if (r_rx_timer < timeout_x) begin
                        n_rx_timer = rx_sum;
                    end else if (r_wr_idx != '0) begin
                        if (r_frame_len == '0) begin
                            n_frame_len = r_wr_idx;
                        end else if (r_rx_timer < hold) begin
                            n_rx_timer = rx_sum;
                            if (rx_sum >= hold) begin
                                n_wr_idx = '0;
                            end
                        end
                    end
                    // Transmit side: delay, then start or finish a transfer.
                    if (r_tx_timer < timeout_x) begin
                        n_tx_timer = tx_sum;
                    end else if (!i_uart_busy) begin
                        if (r_bus == BUS_XFER) begin
                            bus_x  = BUS_FREE;
                            pend_x = '0;
                        end
                        if (pend_x != '0) begin
                            bus_x           = BUS_XFER;
                            o_res.start_tx  = 1'b1;
                            o_res.tx_length = pend_x;
                        end
                        n_bus     = bus_x;
                        n_tx_pend = pend_x;
                    end
                end
                FUNC_READ: begin
                    // Byte comes from the store in the next cycle.
                    o_res.rd_en = (CMP_W'(i_read_index) < CMP_W'(r_frame_len)) &&
                                  (CMP_W'(i_read_index) < CMP_W'(RX_DEPTH));
                end
                FUNC_TAKE: begin
                    if (r_frame_len != '0) begin
                        o_res.length = (LEN_W'(r_frame_len) < i_read_max) ?
                                       LEN_W'(r_frame_len) : i_read_max;
                        n_wr_idx     = '0;
                        n_frame_len  = '0;
                    end
                end
                FUNC_WRITE: begin
                    if (r_tx_cap != '0 && r_bus == BUS_FREE) begin
                        if (cnt > LEN_W'(r_tx_cap)) begin
                            cnt = LEN_W'(r_tx_cap);
                        end
                        n_bus        = BUS_WAIT;
                        n_tx_pend    = cnt;
                        n_tx_timer   = '0;
                        o_res.length = cnt;
                    end
                end
                default: begin
                end
            endcase
        end

        // Status after the item.
        o_res.bus_status  = n_bus;
        o_res.frame_ready = (n_frame_len != '0);
    end

endmodule

// ===== rtl/serial_idle_timeout_framer.sv =====
// ----------------------------------------------------------------------------
// serial_idle_timeout_framer
// Frames a serial byte stream by line-idle timeout and paces host transmits.
//
//  Channel  Dir  Handshake               Payload
//  s_axis   in   tvalid/tready           tuser: func; tdata: request fields
//  m_axis   out  tvalid/tready           tdata: result fields
//  cfg      in   i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// One item per clock while the output is not stalled. A result passes the
// registered read of the receive store in the middle stage and then the
// output register before it is offered on m_axis.
// State updates happen in the cycle the item is accepted; the store read
// lands in a middle stage and the output register follows it.
// Reset is synchronous; the store has no reset and needs no clearing pass.
// A stalled output holds the middle stage, and input is taken again as soon
// as the middle stage can move on.
// ----------------------------------------------------------------------------
module serial_idle_timeout_framer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [sitf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sitf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // func[2:0]
    input  logic [sitf_pkg::FUNC_W-1:0]       s_axis_tuser,
    // rx_byte[7:0], elapsed_ms[23:8], uart_busy[24], read_index[32:25],
    // read_max[48:33], write_count[64:49], zero[71:65]
    input  logic [sitf_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_data[7:0], length[23:8], start_tx[24], tx_length[40:25],
    // bus_status[42:41], frame_ready[43], overflow[44], zero[47:45]
    output logic [sitf_pkg::M_DATA_W-1:0]     m_axis_tdata
);
    import sitf_pkg::*;

    logic                  accept;
    logic                  s1_adv;
    t_store_wr             store_wr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [BYTE_W-1:0]     rd_data;
    t_result               res;

    logic                  r_s1_valid;
    t_result               r_s1_res;
    logic                  r_out_valid;
    logic [M_DATA_W-1:0]   r_out_data;

    // Handshake: the middle stage moves when the output is free or taken.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sitf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_func        (s_axis_tuser),
        .i_rx_byte     (s_axis_tdata[7:0]),
        .i_elapsed_ms  (s_axis_tdata[23:8]),
        .i_uart_busy   (s_axis_tdata[24]),
        .i_read_index  (s_axis_tdata[32:25]),
        .i_read_max    (s_axis_tdata[48:33]),
        .i_write_count (s_axis_tdata[64:49]),
        .o_wr          (store_wr),
        .o_rd_addr     (rd_addr),
        .o_res         (res)
    );

    sitf_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Middle stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Middle stage payload, waits beside the store read data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= res;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: merge the store byte into the result item.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {3'b000,
                           r_s1_res.overflow,
                           r_s1_res.frame_ready,
                           r_s1_res.bus_status,
                           r_s1_res.tx_length,
                           r_s1_res.start_tx,
                           r_s1_res.length,
                           (r_s1_res.rd_en ? rd_data : BYTE_W'(0))};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== test/tb_serial_idle_timeout_framer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_idle_timeout_framer
// Self-checking bench for the serial idle-timeout framer. A behavioral copy
// of the framer state predicts the result of every accepted request item.
// Directed tests cover the reset state, unused operation codes, frame capture
// with overflow and clipping, and transmit pacing. Random phases then run
// under several register settings. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_serial_idle_timeout_framer;

    import sitf_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    // Request fields as packed on s_axis_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]       pad;
        logic [LEN_W-1:0] write_count;
        logic [LEN_W-1:0] read_max;
        logic [7:0]       read_index;
        logic             uart_busy;
        logic [MS_W-1:0]  elapsed_ms;
        logic [BYTE_W-1:0] rx_byte;
    } t_framer_request;

    // Result fields as packed on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [2:0]        pad;
        logic              overflow;
        logic              frame_ready;
        t_bus              bus_status;
        logic [LEN_W-1:0]  tx_length;
        logic              start_tx;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] read_data;
    } t_framer_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [FUNC_W-1:0]     s_axis_tuser = '0;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    // Predicted framer state and registers.
    logic [BYTE_W-1:0]     rx_mem [RX_DEPTH];
    logic [RXCAP_W-1:0]    wr_idx;
    logic [RXCAP_W-1:0]    frm_len;
    logic [TIMER_W-1:0]    rx_tmr;
    logic [TIMER_W-1:0]    tx_tmr;
    t_bus                  bus_st;
    logic [LEN_W-1:0]      tx_pend;
    logic [TIMEOUT_W-1:0]  timeout_val;
    logic [RXCAP_W-1:0]    rx_cap_reg;
    logic [TXCAP_W-1:0]    tx_cap_reg;

    t_framer_result        predicted_results [$];
    int unsigned           mismatches = 0;
    int unsigned           items_sent = 0;
    int unsigned           burst_left = 0;
    int unsigned           stuck_cycles = 0;
    int unsigned           rdy_mode = 0;
    int unsigned           rdy_mode_left = 0;
    int unsigned           rdy_hold_left = 0;
    logic                  rdy_level = 1'b0;

    serial_idle_timeout_framer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicts the result of one request and advances the predicted state.
    function automatic t_framer_result predict_framer_step(input logic [FUNC_W-1:0] code,
                                                           input t_framer_request req);
        t_framer_result     res;
        int unsigned        cap;
        logic [TIMER_W-1:0] hold;
        logic [LEN_W-1:0]   cnt;
        res  = '0;
        cap  = (rx_cap_reg < RX_DEPTH) ? rx_cap_reg : RX_DEPTH;
        hold = TIMER_W'(timeout_val) + TIMER_W'(FRAME_HOLD_MS);
        case (code)
            FUNC_RX_BYTE: begin
                if (cap != 0) begin
                    if (wr_idx >= cap) begin
                        res.overflow = 1'b1;
                    end else begin
                        rx_mem[wr_idx] = req.rx_byte;
                        wr_idx = wr_idx + 1'b1;
                        rx_tmr = '0;
                    end
                end
            end
            FUNC_TICK: begin
                // Receive side: count silence, latch the frame, then age it out.
                if (rx_tmr < timeout_val) begin
                    rx_tmr = rx_tmr + req.elapsed_ms;
                end else if (wr_idx != 0) begin
                    if (frm_len == 0) begin
                        frm_len = wr_idx;
                    end else if (rx_tmr < hold) begin
                        rx_tmr = rx_tmr + req.elapsed_ms;
                        if (rx_tmr >= hold)
                            wr_idx = '0;
                    end
                end
                // Transmit side: wait out the delay, then start or finish.
                if (tx_tmr < timeout_val) begin
                    tx_tmr = tx_tmr + req.elapsed_ms;
                end else if (!req.uart_busy) begin
                    if (bus_st == BUS_XFER) begin
                        bus_st  = BUS_FREE;
                        tx_pend = '0;
                    end
                    if (tx_pend != 0) begin
                        bus_st        = BUS_XFER;
                        res.start_tx  = 1'b1;
                        res.tx_length = tx_pend;
                    end
                end
            end
            FUNC_READ: begin
                if (req.read_index < frm_len)
                    res.read_data = rx_mem[req.read_index];
            end
            FUNC_TAKE: begin
                if (frm_len != 0) begin
                    res.length = (frm_len < req.read_max) ? LEN_W'(frm_len) : req.read_max;
                    wr_idx  = '0;
                    frm_len = '0;
                end
            end
            FUNC_WRITE: begin
                if (tx_cap_reg != 0 && bus_st == BUS_FREE) begin
                    cnt        = (req.write_count > tx_cap_reg) ? tx_cap_reg : req.write_count;
                    bus_st     = BUS_WAIT;
                    tx_pend    = cnt;
                    tx_tmr     = '0;
                    res.length = cnt;
                end
            end
            default: ;
        endcase
        res.bus_status  = bus_st;
        res.frame_ready = (frm_len != 0);
        return res;
    endfunction

    function automatic t_framer_request random_request();
        logic [95:0]     raw;
        t_framer_request req;
        raw     = {$urandom(), $urandom(), $urandom()};
        req     = raw[S_DATA_W-1:0];
        req.pad = '0;
        return req;
    endfunction

    // Mostly short ticks around the timeout, sometimes none, the longest or random.
    function automatic logic [MS_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return MS_W'($urandom());
            default: return MS_W'($urandom_range(0, timeout_val + 20));
        endcase
    endfunction

    // Waits until every predicted result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        logic [TIMEOUT_W-1:0] tmo;
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TIMEOUT: begin
                tmo = value[TIMEOUT_W-1:0];
                timeout_val = (tmo < TIMEOUT_MIN || tmo > TIMEOUT_MAX) ?
                              TIMEOUT_W'(TIMEOUT_FALLBACK) : tmo;
            end
            CFG_RX_CAP: begin
                rx_cap_reg = value[RXCAP_W-1:0];
                wr_idx     = '0;
                frm_len    = '0;
                rx_tmr     = '0;
            end
            CFG_TX_CAP: begin
                tx_cap_reg = value[TXCAP_W-1:0];
                bus_st     = BUS_FREE;
                tx_pend    = '0;
                tx_tmr     = '0;
            end
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Sends one item in bursts with random gaps and predicts its result.
    task automatic send_item(input logic [FUNC_W-1:0] code, input t_framer_request req);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= req;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
        predicted_results.push_back(predict_framer_step(code, req));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        t_framer_request req;
        req = random_request();
        req.rx_byte = value;
        send_item(FUNC_RX_BYTE, req);
    endtask

    task automatic send_tick(input logic [MS_W-1:0] ms, input logic busy);
        t_framer_request req;
        req = random_request();
        req.elapsed_ms = ms;
        req.uart_busy  = busy;
        send_item(FUNC_TICK, req);
    endtask

    task automatic send_read(input logic [7:0] idx);
        t_framer_request req;
        req = random_request();
        req.read_index = idx;
        send_item(FUNC_READ, req);
    endtask

    task automatic send_take(input logic [LEN_W-1:0] max_len);
        t_framer_request req;
        req = random_request();
        req.read_max = max_len;
        send_item(FUNC_TAKE, req);
    endtask

    task automatic send_write(input logic [LEN_W-1:0] count);
        t_framer_request req;
        req = random_request();
        req.write_count = count;
        send_item(FUNC_WRITE, req);
    endtask

    // With no buffers attached every request is ignored or refused.
    task automatic test_idle_defaults();
        send_byte(8'hA5);
        send_take('1);
        send_write('1);
        send_tick('1, 1'b1);
        send_read('0);
    endtask

    task automatic test_unused_codes();
        int c;
        for (c = int'(FUNC_WRITE) + 1; c < (1 << FUNC_W); c++)
            send_item(FUNC_W'(c), random_request());
    endtask

    // A two-byte store: overflow, latch after silence, reads in and out of
    // the frame, a clipped take and a take with no frame left.
    task automatic test_frame_capture();
        write_register(CFG_TIMEOUT, CFG_DATA_W'(TIMEOUT_MIN));
        write_register(CFG_RX_CAP, 16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_tick(MS_W'(TIMEOUT_MIN), 1'b0);
        send_tick('0, 1'b0);
        send_read(8'd1);
        send_read(8'hFF);
        send_take(16'd1);
        send_take('1);
    endtask

    // Clipped write, refused write, busy UART, start, return to idle, and a
    // zero-byte write that leaves the bus busy.
    task automatic test_transmit_pacing();
        write_register(CFG_TX_CAP, 16'd100);
        send_write('1);
        send_write(16'd5);
        send_tick(MS_W'(TIMEOUT_MIN), 1'b1);
        send_tick('0, 1'b1);
        send_tick('0, 1'b0);
        send_tick('0, 1'b0);
        send_write('0);
        send_tick('1, 1'b0);
        write_register(CFG_TX_CAP, '1);
    endtask

    // Random phases under changing settings; mostly well-formed frames and
    // transmit requests with random content, the rest noise.
    task automatic test_random_phases(input int unsigned total);
        int unsigned       ph, stop_at, cap, n, k;
        logic [FUNC_W-1:0] code;
        logic [LEN_W-1:0]  cnt;
        t_framer_request   req;
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_register(CFG_TIMEOUT, CFG_DATA_W'(TIMEOUT_MIN));
                    write_register(CFG_RX_CAP, 16'd1);
                    write_register(CFG_TX_CAP, 16'd1);
                end
                1: begin
                    write_register(CFG_TIMEOUT, CFG_DATA_W'(TIMEOUT_MAX));
                    write_register(CFG_RX_CAP, CFG_DATA_W'(RX_DEPTH));
                    write_register(CFG_TX_CAP, '1);
                end
                2: begin
                    write_register(CFG_TIMEOUT, CFG_DATA_W'(TIMEOUT_MIN - 1));
                    write_register(CFG_RX_CAP, 16'd16);
                    write_register(CFG_TX_CAP, '0);
                end
                3: begin
                    write_register(CFG_TIMEOUT, 16'h0FFF);
                    write_register(CFG_RX_CAP, 16'hFE00);
                    write_register(CFG_TX_CAP, 16'd300);
                end
                4: begin
                    write_register(CFG_TIMEOUT, CFG_DATA_W'(TIMEOUT_MAX + 1));
                    write_register(CFG_RX_CAP, 16'h01FF);
                    write_register(CFG_TX_CAP, CFG_DATA_W'($urandom_range(1, 400)));
                end
                default: begin
                    write_register(CFG_TIMEOUT, ($urandom_range(0, 3) == 0) ?
                                   CFG_DATA_W'($urandom()) :
                                   CFG_DATA_W'($urandom_range(TIMEOUT_MIN, TIMEOUT_MAX)));
                    write_register(CFG_RX_CAP, ($urandom_range(0, 4) == 0) ?
                                   CFG_DATA_W'($urandom_range(0, 511)) :
                                   CFG_DATA_W'($urandom_range(1, 16)));
                    write_register(CFG_TX_CAP, ($urandom_range(0, 4) == 0) ?
                                   CFG_DATA_W'($urandom()) :
                                   CFG_DATA_W'($urandom_range(1, 400)));
                end
            endcase
            stop_at = items_sent + total / 8;
            while (items_sent < stop_at) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        // A frame: bytes, silence until it latches, reads, take.
                        // Small stores are sometimes overrun on purpose.
                        cap = (rx_cap_reg < RX_DEPTH) ? rx_cap_reg : RX_DEPTH;
                        n = ($urandom_range(0, 15) == 0 && cap <= 16) ? cap + 2 :
                            $urandom_range(1, ((cap < 12) ? cap : 12) + 2);
                        for (k = 0; k < n; k++)
                            send_byte(BYTE_W'($urandom()));
                        for (k = 0; k < 6 && frm_len == 0; k++)
                            send_tick(MS_W'($urandom_range(timeout_val / 2, timeout_val + 5)),
                                      ($urandom_range(0, 3) == 0));
                        n = $urandom_range(0, 3);
                        for (k = 0; k < n; k++)
                            send_read(($urandom_range(0, 4) == 0) ? 8'($urandom()) :
                                      8'($urandom_range(0, frm_len)));
                        if ($urandom_range(0, 4) != 0)
                            send_take(($urandom_range(0, 1) == 0) ? LEN_W'($urandom()) :
                                      LEN_W'($urandom_range(0, frm_len + 2)));
                    end
                    4, 5, 6: begin
                        // A host write, then ticks until the bus is idle again.
                        case ($urandom_range(0, 19))
                            0:       cnt = '0;
                            1, 2:    cnt = '1;
                            3, 4:    cnt = tx_cap_reg;
                            default: cnt = LEN_W'($urandom_range(1, 300));
                        endcase
                        send_write(cnt);
                        for (k = 0; k < 8 && bus_st != BUS_FREE; k++)
                            send_tick(pick_elapsed(), ($urandom_range(0, 3) == 0));
                    end
                    default: begin
                        code = FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1));
                        req  = random_request();
                        if (code == FUNC_TICK)
                            req.elapsed_ms = pick_elapsed();
                        send_item(code, req);
                    end
                endcase
            end
        end
    endtask

    // Receiver ready: phases of always ready, coin flips and long stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rdy_mode_left == 0) begin
                rdy_mode      = $urandom_range(0, 2);
                rdy_mode_left = $urandom_range(50, 300);
            end
            rdy_mode_left--;
            case (rdy_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: begin
                    if (rdy_hold_left == 0) begin
                        rdy_hold_left = $urandom_range(1, 12);
                        rdy_level     = ~rdy_level;
                    end
                    rdy_hold_left--;
                    m_axis_tready <= rdy_level;
                end
            endcase
        end
    end

    // Compares each result item with the oldest prediction.
    always @(posedge i_clk) begin
        t_framer_result got;
        t_framer_result want;
        string          bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end else begin
                want = predicted_results.pop_front();
                bad  = "";
                if (got.read_data !== want.read_data)     bad = {bad, " read_data"};
                if (got.length !== want.length)           bad = {bad, " length"};
                if (got.start_tx !== want.start_tx)       bad = {bad, " start_tx"};
                if (got.tx_length !== want.tx_length)     bad = {bad, " tx_length"};
                if (got.bus_status !== want.bus_status)   bad = {bad, " bus_status"};
                if (got.frame_ready !== want.frame_ready) bad = {bad, " frame_ready"};
                if (got.overflow !== want.overflow)       bad = {bad, " overflow"};
                if (got.pad !== want.pad)                 bad = {bad, " padding"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch in%s: expected %h, got %h", bad, want, got);
                end
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // Predicted reset state; the store is only read where it was written.
        wr_idx      = '0;
        frm_len     = '0;
        rx_tmr      = '0;
        tx_tmr      = '0;
        bus_st      = BUS_FREE;
        tx_pend     = '0;
        timeout_val = TIMEOUT_W'(TIMEOUT_RESET);
        rx_cap_reg  = '0;
        tx_cap_reg  = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_defaults();
        test_unused_codes();
        test_frame_capture();
        test_transmit_pacing();
        test_random_phases(424);

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
